@@ hw/rtl/crc32s_pkg.sv @@
// ----------------------------------------------------------------------------
// crc32s_pkg
// Shared types, constants and the byte table function for the MSB-first
// byte-serial CRC-32 stream block.
// ----------------------------------------------------------------------------
package crc32s_pkg;

  localparam logic [31:0] CrcPoly   = 32'h04C1_1DB7;
  localparam logic [2:0]  SeenFull  = 3'd4;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned CrcWidth  = 32;

  typedef struct packed {
    logic [ByteWidth-1:0] data_byte;
    logic                 last_byte;
  } item_t;

  // non-reflected table value of one outgoing top byte
  function automatic logic [CrcWidth-1:0] crc_table_entry(input logic [ByteWidth-1:0] top);
    logic [CrcWidth-1:0] r;
    r = {top, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      if (r[CrcWidth-1]) begin
        r = {r[CrcWidth-2:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[CrcWidth-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/crc32s_in_reg.sv @@
// ----------------------------------------------------------------------------
// crc32s_in_reg
// Input register stage: captures one byte per cycle while not stalled and holds it while the
// checksum stage is blocked by a stalled result.
// ----------------------------------------------------------------------------
module crc32s_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  input  logic                core_busy,
  output logic                item_valid,
  output crc32s_pkg::item_t   item
);

  logic              valid_r;
  logic              valid_nxt;
  crc32s_pkg::item_t item_r;
  logic              load;

  assign in_stall  = valid_r && core_busy;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (valid_r && core_busy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.data_byte <= in_data_byte;
      item_r.last_byte <= in_last_byte;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ hw/rtl/crc32s_core.sv @@
// ----------------------------------------------------------------------------
// crc32s_core
// Running CRC register, byte counter and result register. Packs the first
// four bytes, then folds each further byte through the table.
// ----------------------------------------------------------------------------
module crc32s_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  crc32s_pkg::item_t  item,
  output logic               core_busy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_checksum
);

  logic [31:0] acc_r;
  logic [31:0] acc_nxt;
  logic [2:0]  seen_r;
  logic [2:0]  seen_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] checksum_r;
  logic [31:0] step_acc;
  logic [2:0]  step_seen;
  logic [31:0] packed_acc;
  logic        fire;
  logic        emit;

  assign core_busy = out_valid_r && out_stall;
  assign fire      = item_valid && !core_busy;
  assign emit      = fire && item.last_byte;

  always_comb begin
    packed_acc = acc_r;
    unique case (seen_r)
      3'd0:    packed_acc = acc_r | {item.data_byte, 24'h00_0000};
      3'd1:    packed_acc = acc_r | {8'h00, item.data_byte, 16'h0000};
      3'd2:    packed_acc = acc_r | {16'h0000, item.data_byte, 8'h00};
      3'd3:    packed_acc = acc_r | {24'h00_0000, item.data_byte};
      default: packed_acc = acc_r;
    endcase
  end

  always_comb begin
    if (seen_r < crc32s_pkg::SeenFull) begin
      step_seen = seen_r + 3'd1;
      step_acc  = (step_seen == crc32s_pkg::SeenFull) ? ~packed_acc : packed_acc;
    end else begin
      step_seen = seen_r;
      step_acc  = {acc_r[23:0], item.data_byte} ^ crc32s_pkg::crc_table_entry(acc_r[31:24]);
    end
  end

  always_comb begin
    acc_nxt  = acc_r;
    seen_nxt = seen_r;
    if (fire) begin
      if (item.last_byte) begin
        acc_nxt  = '0;
        seen_nxt = '0;
      end else begin
        acc_nxt  = step_acc;
        seen_nxt = step_seen;
      end
    end
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      checksum_r <= (step_seen == crc32s_pkg::SeenFull) ? ~step_acc : step_acc;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = checksum_r;

`ifndef SYNTH
  a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= crc32s_pkg::SeenFull)
    else $error("byte count out of range");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid_r && seen_r == 3'd0 && acc_r == 32'h0))
    else $error("message end did not restart state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !fire)
    else $error("word taken while result stalled");

  a_seen_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !item.last_byte && seen_r < crc32s_pkg::SeenFull) |=>
      (seen_r == $past(seen_r) + 3'd1))
    else $error("byte count did not advance");
`endif

endmodule

@@ hw/rtl/crc32_msb_first_stream.sv @@
// result path: an accepted last byte is held in the input register, then sets out_valid
// throughput: one byte per cycle while no stalled result blocks the core; the crc register packs or folds each byte
// stalls: a stalled result holds the input register, which then stalls input
// reset: synchronous active-low rst_n clears the crc register, byte count
//   and both valid flags; the next byte starts a new message
// ----------------------------------------------------------------------------
// crc32_msb_first_stream
// Byte-serial MSB-first CRC-32 (poly 04C11DB7) over a framed byte stream,
// one checksum word per message.
// ----------------------------------------------------------------------------
module crc32_msb_first_stream (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_checksum
);

  logic              item_valid;
  crc32s_pkg::item_t item;
  logic              core_busy;

  crc32s_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .core_busy    (core_busy),
    .item_valid   (item_valid),
    .item         (item)
  );

  crc32s_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item         (item),
    .core_busy    (core_busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_checksum (out_checksum)
  );

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for crc32_msb_first_stream: framed byte messages of
// many lengths go in, and each checksum word coming out is compared with a
// bit-serial prediction of the MSB-first CRC-32, with random idling on both
// sides.
// ----------------------------------------------------------------------------
typedef logic [crc32s_pkg::ByteWidth-1:0] msg_bytes_t[$];

class crc_scoreboard;
  logic [crc32s_pkg::CrcWidth-1:0] crc_reg;
  logic [2:0]                      packed_count;
  logic [crc32s_pkg::CrcWidth-1:0] expected_sums[$];
  int unsigned                     mismatches;
  int unsigned                     sums_checked;

  function new();
    crc_reg      = '0;
    packed_count = '0;
    mismatches   = 0;
    sums_checked = 0;
  endfunction

  // shift the byte in bit by bit, folding the polynomial on each carry out
  function automatic logic [crc32s_pkg::CrcWidth-1:0] fold_byte(
      input logic [crc32s_pkg::CrcWidth-1:0]  r,
      input logic [crc32s_pkg::ByteWidth-1:0] d);
    logic carry;
    for (int i = crc32s_pkg::ByteWidth - 1; i >= 0; i--) begin
      carry = r[crc32s_pkg::CrcWidth-1];
      r = {r[crc32s_pkg::CrcWidth-2:0], d[i]};
      if (carry) begin
        r = r ^ crc32s_pkg::CrcPoly;
      end
    end
    return r;
  endfunction

  function void note_byte(input logic [crc32s_pkg::ByteWidth-1:0] d, input logic last);
    if (packed_count < crc32s_pkg::SeenFull) begin
      crc_reg = crc_reg | ({24'h0, d} << (24 - 8 * packed_count));
      packed_count = packed_count + 3'd1;
      if (packed_count == crc32s_pkg::SeenFull) begin
        crc_reg = ~crc_reg;
      end
    end else begin
      crc_reg = fold_byte(crc_reg, d);
    end
    if (last) begin
      expected_sums.push_back(packed_count == crc32s_pkg::SeenFull ? ~crc_reg : crc_reg);
      crc_reg      = '0;
      packed_count = '0;
    end
  endfunction

  function void check_checksum(input logic [crc32s_pkg::CrcWidth-1:0] actual);
    logic [crc32s_pkg::CrcWidth-1:0] want;
    if (expected_sums.size() == 0) begin
      $error("checksum: unexpected word 0x%08h with nothing pending", actual);
      mismatches++;
      return;
    end
    want = expected_sums.pop_front();
    sums_checked++;
    if (actual !== want) begin
      $error("checksum: expected 0x%08h, actual 0x%08h", want, actual);
      mismatches++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [31:0] out_checksum;

  crc_scoreboard sb = new();

  bit          idling_on = 1'b1;
  int unsigned gap_odds  = 4;
  int unsigned bytes_sent;
  int unsigned messages_sent;

  crc32_msb_first_stream dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_checksum (out_checksum)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (idling_on && rst_n && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_checksum(out_checksum);
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic last);
    if (idling_on && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    sb.note_byte(d, last);
    bytes_sent++;
  endtask

  task automatic send_message(input msg_bytes_t msg);
    for (int i = 0; i < msg.size(); i++) begin
      send_byte(msg[i], i == msg.size() - 1);
    end
    messages_sent++;
  endtask

  task automatic send_random_message();
    msg_bytes_t  msg;
    int unsigned len;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      len = $urandom_range(1, 8);
    end else if (pick < 95) begin
      len = $urandom_range(9, 24);
    end else begin
      len = $urandom_range(25, 64);
    end
    for (int i = 0; i < len; i++) begin
      msg.push_back(8'($urandom));
    end
    send_message(msg);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short messages, packing only, then inversion and folding
    send_message('{8'hFF});
    send_message('{8'h00});
    send_message('{8'h12, 8'h34});
    send_message('{8'hAB, 8'hCD, 8'hEF});
    send_message('{8'h00, 8'h00, 8'h00, 8'h00});
    send_message('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_message('{8'h80, 8'h01, 8'hFF, 8'h00, 8'h7F});
    send_message('{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39});

    while (bytes_sent < 750) begin
      idling_on = (bytes_sent < 650);
      case ($urandom_range(0, 3))
        0: gap_odds = 0;
        1: gap_odds = 2;
        default: gap_odds = 6;
      endcase
      send_random_message();
    end
    in_valid <= 1'b0;

    while (sb.expected_sums.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d messages, %0d bytes, %0d checksum words compared",
             messages_sent, bytes_sent, sb.sums_checked);
    if (sb.mismatches == 0) begin
      $display("PASS crc32_msb_first_stream");
    end else begin
      $display("FAIL crc32_msb_first_stream");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL crc32_msb_first_stream");
    $finish;
  end

endmodule
